[rtl/single_source_shortest_path_unit_macros.svh]
// assertion helpers for the shortest path unit
`ifndef SINGLE_SOURCE_SHORTEST_PATH_UNIT_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define SSSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sssp assertion failed");

// next-cycle implication, off during reset
`define SSSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sssp assertion failed");

`endif

[rtl/sssp_pkg.sv]
package sssp_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int MAX_EDGES_DEF   = 256;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_BITS         = 6;
  localparam int COUNT_BITS        = 7;
  localparam int WEIGHT_FIELD_BITS = 16;
  // path lengths stay at or below 63 * 65535, so 23 bits hold any tentative sum
  localparam int DIST_BITS         = 23;
  localparam int DIST_OUT_BITS     = 22;
  localparam logic [DIST_OUT_BITS-1:0] DIST_OUT_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_RUN   = 2'd2
  } func_t;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SCAN_RD  = 8'b0000_0010,
    ST_SCAN_CMP = 8'b0000_0100,
    ST_EDGE_RD  = 8'b0000_1000,
    ST_EDGE_CHK = 8'b0001_0000,
    ST_DIST_CMP = 8'b0010_0000,
    ST_OUT_RD   = 8'b0100_0000,
    ST_OUT_EMIT = 8'b1000_0000
  } state_t;

endpackage

[rtl/single_source_shortest_path_unit.sv]
// edge load and clear: a new command can follow every cycle
// run: each round scans the n nodes in use for the nearest unsettled reachable node,
//   settles it and walks all E stored edges to relax its out-edges; the distance memory
//   has a single read port; the results then follow for every node in use
// results stream out in node order, one strobe cycle each; the receiver cannot stall
// rst (synchronous): edge store empty, overflow flag clear, node_count = MAX_NODES
`include "single_source_shortest_path_unit_macros.svh"

module single_source_shortest_path_unit
  import sssp_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func,
  input  logic [NODE_BITS-1:0]         edge_from,
  input  logic [NODE_BITS-1:0]         edge_to,
  input  logic [WEIGHT_FIELD_BITS-1:0] edge_weight,
  input  logic [NODE_BITS-1:0]         source_node,
  // node_count register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [COUNT_BITS-1:0]        cfg_data,
  // result beats
  output logic                         strobe,
  output logic [NODE_BITS-1:0]         node,
  output logic [DIST_OUT_BITS-1:0]     distance,
  output logic                         reachable,
  output logic [NODE_BITS-1:0]         predecessor,
  output logic                         has_predecessor,
  output logic                         edges_dropped,
  output logic                         last
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int CWB = (WEIGHT_BITS < WEIGHT_FIELD_BITS) ? WEIGHT_BITS : WEIGHT_FIELD_BITS;

  // edge store, written in load order
  logic [NODE_BITS-1:0] edge_tail_mem [MAX_EDGES];
  logic [NODE_BITS-1:0] edge_head_mem [MAX_EDGES];
  logic [CWB-1:0]       edge_cost_mem [MAX_EDGES];
  logic [NODE_BITS-1:0] tail_q;
  logic [NODE_BITS-1:0] head_q;
  logic [CWB-1:0]       cost_q;

  logic [ETW-1:0]        edge_total;
  logic                  overflow_seen;
  logic [COUNT_BITS-1:0] node_count;

  // per-node distance and predecessor memories, flags in flops
  logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
  logic [NW-1:0]        prev_mem [MAX_NODES];
  logic [DIST_BITS-1:0] dist_q;
  logic [NW-1:0]        prev_q;
  logic [MAX_NODES-1:0] reach;
  logic [MAX_NODES-1:0] settled;
  logic [MAX_NODES-1:0] prev_valid;

  state_t state, state_next;

  logic [COUNT_BITS-1:0] n_use;     // nodes in use for this run
  logic [COUNT_BITS-1:0] idx;       // node walk counter, holds n_use at the end
  logic [ETW-1:0]        eidx;      // edge walk counter
  logic                  found;
  logic [NW-1:0]         u;         // node settled in this round
  logic [DIST_BITS-1:0]  best_d;    // its distance, also the scan minimum

  logic                  accept;
  logic                  add_ok;
  logic [COUNT_BITS-1:0] n_clamp;
  logic                  src_in_use;
  logic [NW-1:0]         v;
  logic                  edge_match;

  // shared arithmetic: one adder and one less-than compare
  logic [DIST_BITS-1:0]  cand;
  logic [DIST_BITS-1:0]  cmp_a;
  logic [DIST_BITS-1:0]  cmp_b;
  logic                  cmp_lt;

  // distance memory port control
  logic [NW-1:0]         rd_addr;
  logic                  dist_we;
  logic                  prev_we;
  logic [NW-1:0]         wr_addr;
  logic [DIST_BITS-1:0]  wr_data;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign add_ok    = accept && (func == FUNC_ADD) && (edge_total < ETW'(MAX_EDGES));

  // zero nodes counts as one, anything above capacity as capacity
  assign n_clamp = (node_count == '0) ? COUNT_BITS'(1) :
                   (node_count > COUNT_BITS'(MAX_NODES)) ? COUNT_BITS'(MAX_NODES) : node_count;
  assign src_in_use = {1'b0, source_node} < n_clamp;

  assign v          = head_q[NW-1:0];
  assign edge_match = (tail_q == NODE_BITS'(u)) && ({1'b0, head_q} < n_use);

  assign cand   = best_d + DIST_BITS'(cost_q);
  assign cmp_a  = (state == ST_DIST_CMP) ? cand   : dist_q;
  assign cmp_b  = (state == ST_DIST_CMP) ? dist_q : best_d;
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_next = state;
    rd_addr    = idx[NW-1:0];
    dist_we    = 1'b0;
    prev_we    = 1'b0;
    wr_addr    = v;
    wr_data    = cand;
    case (state)
      ST_IDLE: begin
        // source starts at distance zero
        wr_addr = source_node[NW-1:0];
        wr_data = '0;
        if (accept && (func == FUNC_RUN)) begin
          dist_we    = src_in_use;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (idx == n_use) begin
          state_next = found ? ST_EDGE_RD : ST_OUT_RD;
        end else if (reach[idx[NW-1:0]] && !settled[idx[NW-1:0]]) begin
          state_next = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        state_next = ST_SCAN_RD;
      end
      ST_EDGE_RD: begin
        state_next = (eidx == edge_total) ? ST_SCAN_RD : ST_EDGE_CHK;
      end
      ST_EDGE_CHK: begin
        rd_addr    = v;
        state_next = edge_match ? ST_DIST_CMP : ST_EDGE_RD;
      end
      ST_DIST_CMP: begin
        // strict test keeps the first edge that reaches a minimum
        if (!reach[v] || cmp_lt) begin
          dist_we = 1'b1;
          prev_we = 1'b1;
        end
        state_next = ST_EDGE_RD;
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        state_next = (idx + COUNT_BITS'(1) == n_use) ? ST_IDLE : ST_OUT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      edge_tail_mem[edge_total[EIW-1:0]] <= edge_from;
      edge_head_mem[edge_total[EIW-1:0]] <= edge_to;
      edge_cost_mem[edge_total[EIW-1:0]] <= edge_weight[CWB-1:0];
    end
    if (state == ST_EDGE_RD) begin
      tail_q <= edge_tail_mem[eidx[EIW-1:0]];
      head_q <= edge_head_mem[eidx[EIW-1:0]];
      cost_q <= edge_cost_mem[eidx[EIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[wr_addr] <= wr_data;
    end
    if (prev_we) begin
      prev_mem[wr_addr] <= u;
    end
    dist_q <= dist_mem[rd_addr];
    prev_q <= prev_mem[rd_addr];
  end

  // edge bookkeeping and the node_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total    <= '0;
      overflow_seen <= 1'b0;
      node_count    <= COUNT_BITS'(MAX_NODES);
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if (accept) begin
        case (func)
          FUNC_ADD: begin
            if (add_ok) begin
              edge_total <= edge_total + ETW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          FUNC_CLEAR: begin
            edge_total    <= '0;
            overflow_seen <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      strobe     <= 1'b0;
      reach      <= '0;
      settled    <= '0;
      prev_valid <= '0;
      found      <= 1'b0;
      idx        <= '0;
      eidx       <= '0;
    end else begin
      state  <= state_next;
      // a beat follows each emit step
      strobe <= (state == ST_OUT_EMIT);
      case (state)
        ST_IDLE: begin
          if (accept && (func == FUNC_RUN)) begin
            settled    <= '0;
            prev_valid <= '0;
            // only the source starts out reached
            reach      <= src_in_use ? (MAX_NODES'(1) << source_node[NW-1:0]) : '0;
            n_use      <= n_clamp;
            idx        <= '0;
            found      <= 1'b0;
          end
        end
        ST_SCAN_RD: begin
          if (idx == n_use) begin
            idx  <= '0;
            eidx <= '0;
            if (found) begin
              settled[u] <= 1'b1;
            end
          end else if (!(reach[idx[NW-1:0]] && !settled[idx[NW-1:0]])) begin
            idx <= idx + COUNT_BITS'(1);
          end
        end
        ST_SCAN_CMP: begin
          // lowest index wins ties since only a strict drop replaces it
          if (!found || cmp_lt) begin
            found <= 1'b1;
          end
          idx <= idx + COUNT_BITS'(1);
        end
        ST_EDGE_RD: begin
          if (eidx == edge_total) begin
            idx   <= '0;
            found <= 1'b0;
          end else begin
            eidx <= eidx + ETW'(1);
          end
        end
        ST_DIST_CMP: begin
          if (!reach[v] || cmp_lt) begin
            reach[v]      <= 1'b1;
            prev_valid[v] <= 1'b1;
          end
        end
        ST_OUT_EMIT: begin
          idx <= idx + COUNT_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // scan minimum and result payload
  always_ff @(posedge clk) begin
    if (state == ST_SCAN_CMP && (!found || cmp_lt)) begin
      u      <= idx[NW-1:0];
      best_d <= dist_q;
    end
    if (state == ST_OUT_EMIT) begin
      node            <= NODE_BITS'(idx);
      reachable       <= reach[idx[NW-1:0]];
      has_predecessor <= prev_valid[idx[NW-1:0]];
      predecessor     <= prev_valid[idx[NW-1:0]] ? NODE_BITS'(prev_q) : '0;
      edges_dropped   <= overflow_seen;
      last            <= (idx + COUNT_BITS'(1) == n_use);
      if (!reach[idx[NW-1:0]]) begin
        distance <= '0;
      end else if (dist_q > DIST_BITS'(DIST_OUT_MAX)) begin
        distance <= DIST_OUT_MAX;
      end else begin
        distance <= dist_q[DIST_OUT_BITS-1:0];
      end
    end
  end

  // a beat only follows the emit step of the walk
  `SSSP_ASSERT_NOW(a_strobe_from_emit, strobe, $past(state == ST_OUT_EMIT))
  // only the final beat of a run may show once the block is free again
  `SSSP_ASSERT_NOW(a_beat_while_busy, strobe && !last, busy)
  // a settled node has always been reached in this run
  `SSSP_ASSERT_NOW(a_settled_reached, 1'b1, (settled & ~reach) == '0)
  // an accepted run holds the command channel off
  `SSSP_ASSERT_NEXT(a_run_goes_busy, accept && (func == FUNC_RUN), busy)

endmodule

[bench/tb_single_source_shortest_path_unit.sv]
`timescale 1ns / 100ps

module tb_single_source_shortest_path_unit;
  import sssp_pkg::*;

  localparam int MAX_N = MAX_NODES_DEF;
  localparam int MAX_E = MAX_EDGES_DEF;
  // the fourth command code has no meaning, the block must ignore it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // cycles after the last report before the block is surely idle again
  localparam int DRAIN_CYCLES = 8;
  // stop feeding random commands after this many add, clear and run beats
  localparam int COMMAND_TARGET = 250;

  // one node report as it leaves the block
  typedef struct packed {
    logic [NODE_BITS-1:0]     node;
    logic [DIST_OUT_BITS-1:0] dist_out;
    logic                     reach;
    logic [NODE_BITS-1:0]     pred;
    logic                     has_pred;
    logic                     dropped;
    logic                     last;
  } node_report_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // one row of the directed part: a command beat or a node_count write,
  // n_known > 0 marks a run whose reports are typed in below
  typedef struct packed {
    row_kind_t                    kind;
    logic [1:0]                   op;
    logic [NODE_BITS-1:0]         from;
    logic [NODE_BITS-1:0]         to;
    logic [WEIGHT_FIELD_BITS-1:0] weight;
    logic [NODE_BITS-1:0]         src;
    logic [COUNT_BITS-1:0]        count;
    logic [7:0]                   n_known;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   func = FUNC_ADD;
  logic [NODE_BITS-1:0]         edge_from = '0;
  logic [NODE_BITS-1:0]         edge_to = '0;
  logic [WEIGHT_FIELD_BITS-1:0] edge_weight = '0;
  logic [NODE_BITS-1:0]         source_node = '0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [COUNT_BITS-1:0]        cfg_data = '0;
  logic                         strobe;
  logic [NODE_BITS-1:0]         node;
  logic [DIST_OUT_BITS-1:0]     distance;
  logic                         reachable;
  logic [NODE_BITS-1:0]         predecessor;
  logic                         has_predecessor;
  logic                         edges_dropped;
  logic                         last;

  single_source_shortest_path_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .edge_from       (edge_from),
    .edge_to         (edge_to),
    .edge_weight     (edge_weight),
    .source_node     (source_node),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .strobe          (strobe),
    .node            (node),
    .distance        (distance),
    .reachable       (reachable),
    .predecessor     (predecessor),
    .has_predecessor (has_predecessor),
    .edges_dropped   (edges_dropped),
    .last            (last)
  );

  // shadow of the block: edge store, overflow flag, node_count register
  logic [NODE_BITS-1:0]         store_tail [MAX_E];
  logic [NODE_BITS-1:0]         store_head [MAX_E];
  logic [WEIGHT_FIELD_BITS-1:0] store_cost [MAX_E];
  int unsigned                  store_count = 0;
  bit                           store_overflow = 1'b0;
  logic [COUNT_BITS-1:0]        node_count_reg = COUNT_BITS'(MAX_N);

  node_report_t pending_node_reports [$];
  node_report_t known_node_reports [$];
  step_t        directed_steps [$];

  int unsigned commands_sent = 0;
  bit          no_gaps = 1'b0;
  bit          failed = 1'b0;

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // zero and anything above the node limit fold into the legal range
  function automatic int unsigned effective_nodes(input logic [COUNT_BITS-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_N) return MAX_N;
    return count;
  endfunction

  // mostly a node in use, now and then any node at all
  function automatic logic [NODE_BITS-1:0] pick_node(input int unsigned n);
    if ($urandom_range(0, 9) == 0) return NODE_BITS'($urandom_range(0, MAX_N - 1));
    return NODE_BITS'($urandom_range(0, n - 1));
  endfunction

  // small weights make ties between paths common
  function automatic logic [WEIGHT_FIELD_BITS-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return WEIGHT_FIELD_BITS'($urandom_range(0, 7));
      default: return WEIGHT_FIELD_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // dijkstra over the shadow store, one report per node in use
  task automatic predict_paths(input int unsigned src);
    int unsigned  n;
    int unsigned  u;
    int unsigned  v;
    int unsigned  cand;
    int unsigned  d;
    int unsigned  dist_tab [MAX_N];
    int unsigned  pred_tab [MAX_N];
    bit           reach_tab [MAX_N];
    bit           done_tab [MAX_N];
    bit           pv_tab [MAX_N];
    bit           found;
    node_report_t rep;
    n = effective_nodes(node_count_reg);
    for (int i = 0; i < MAX_N; i++) begin
      dist_tab[i]  = 0;
      pred_tab[i]  = 0;
      reach_tab[i] = 1'b0;
      done_tab[i]  = 1'b0;
      pv_tab[i]    = 1'b0;
    end
    // a source outside the nodes in use reaches nothing
    found = (src < n);
    if (found) reach_tab[src] = 1'b1;
    for (int r = 0; r < n && found; r++) begin
      // least distance wins, lowest index on a tie
      u = n;
      for (int i = 0; i < n; i++) begin
        if (reach_tab[i] && !done_tab[i] && (u == n || dist_tab[i] < dist_tab[u])) u = i;
      end
      found = (u != n);
      if (found) begin
        done_tab[u] = 1'b1;
        // relax in load order, strict less-than keeps the first predecessor
        for (int e = 0; e < store_count; e++) begin
          v = store_head[e];
          cand = dist_tab[u] + store_cost[e];
          if (store_tail[e] == u && v < n && (!reach_tab[v] || cand < dist_tab[v])) begin
            reach_tab[v] = 1'b1;
            dist_tab[v]  = cand;
            pred_tab[v]  = u;
            pv_tab[v]    = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      d = reach_tab[i] ? dist_tab[i] : 0;
      if (d > DIST_OUT_MAX) d = DIST_OUT_MAX;
      rep.node     = NODE_BITS'(i);
      rep.dist_out = d[DIST_OUT_BITS-1:0];
      rep.reach    = reach_tab[i];
      rep.pred     = pv_tab[i] ? NODE_BITS'(pred_tab[i]) : '0;
      rep.has_pred = pv_tab[i];
      rep.dropped  = store_overflow;
      rep.last     = (i == n - 1);
      pending_node_reports.push_back(rep);
    end
  endtask

  // hold one command beat until the block takes it, then update the shadow
  task automatic send_command(input logic [1:0] op, input logic [NODE_BITS-1:0] from,
                              input logic [NODE_BITS-1:0] to,
                              input logic [WEIGHT_FIELD_BITS-1:0] weight,
                              input logic [NODE_BITS-1:0] src, input bit reports_known);
    start       <= 1'b1;
    func        <= op;
    edge_from   <= from;
    edge_to     <= to;
    edge_weight <= weight;
    source_node <= src;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      FUNC_ADD: begin
        if (store_count < MAX_E) begin
          store_tail[store_count] = from;
          store_head[store_count] = to;
          store_cost[store_count] = weight;
          store_count++;
        end else begin
          // store full, the edge is lost
          store_overflow = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        store_count    = 0;
        store_overflow = 1'b0;
      end
      FUNC_RUN: if (!reports_known) predict_paths(src);
      default: ;
    endcase
    if (op != FUNC_UNUSED) commands_sent++;
  endtask

  // random pause on the command side, mostly short
  task automatic take_break();
    int unsigned gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(6, 40);
        default: gap = 0;
      endcase
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // node_count is only written once every report is in and the block is idle
  task automatic write_node_count(input logic [COUNT_BITS-1:0] count);
    start <= 1'b0;
    while (pending_node_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + $urandom_range(0, 5)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_count_reg = count;
  endtask

  // report beats: one per strobe, checked against the oldest expectation
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  node_report_t want_rep;

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_node_reports.size() == 0) begin
        $display("%0t report beat for node %0d with nothing expected", $time, node);
        failed = 1'b1;
      end else begin
        want_rep = pending_node_reports.pop_front();
        check_field("node", want_rep.node, node);
        check_field("distance", want_rep.dist_out, distance);
        check_field("reachable", want_rep.reach, reachable);
        check_field("predecessor", want_rep.pred, predecessor);
        check_field("has_predecessor", want_rep.has_pred, has_predecessor);
        check_field("edges_dropped", want_rep.dropped, edges_dropped);
        check_field("last", want_rep.last, last);
      end
    end
  end

  initial begin : stimulus
    step_t       s;
    int unsigned n;
    int unsigned n_edges;
    int unsigned n_runs;
    int unsigned phase;
    bit          big;
    logic [COUNT_BITS-1:0] count;

    // directed part: reset state, extremes, ignored edges, folded counts
    // run right after reset: 64 nodes, empty store
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_ADD, 6'd63, 6'd62, 16'hFFFF, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd63, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CFG, FUNC_ADD, 6'd0, 6'd0, 16'd0, 6'd0, 7'd3, 8'd0});
    // chain of maximum weights, plus an edge into a node not in use
    directed_steps.push_back('{ROW_CMD, FUNC_ADD, 6'd0, 6'd1, 16'hFFFF, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_ADD, 6'd1, 6'd2, 16'hFFFF, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_ADD, 6'd2, 6'd63, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd3});
    // source not in use
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd63, 7'd0, 8'd3});
    directed_steps.push_back('{ROW_CMD, FUNC_UNUSED, 6'd5, 6'd6, 16'd9, 6'd1, 7'd0, 8'd0});
    // zero-weight shortcut, and a longer path that must not win
    directed_steps.push_back('{ROW_CMD, FUNC_ADD, 6'd0, 6'd2, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_ADD, 6'd1, 6'd2, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_CLEAR, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd1, 7'd0, 8'd3});
    // node_count zero acts as one node, self loop never improves the source
    directed_steps.push_back('{ROW_CFG, FUNC_ADD, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_ADD, 6'd0, 6'd0, 16'd7, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd1});
    // node_count above the limit acts as 64
    directed_steps.push_back('{ROW_CFG, FUNC_ADD, 6'd0, 6'd0, 16'd0, 6'd0, 7'd127, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CFG, FUNC_ADD, 6'd0, 6'd0, 16'd0, 6'd0, 7'd64, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_CLEAR, 6'd0, 6'd0, 16'd0, 6'd0, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_UNUSED, 6'd63, 6'd63, 16'hFFFF, 6'd63, 7'd0, 8'd0});
    directed_steps.push_back('{ROW_CMD, FUNC_RUN, 6'd0, 6'd0, 16'd0, 6'd63, 7'd0, 8'd0});

    // typed reports: node, distance, reachable, predecessor, has_predecessor,
    // edges_dropped, last
    // chain run from node 0
    known_node_reports.push_back('{6'd0, 22'd0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0});
    known_node_reports.push_back('{6'd1, 22'd65535, 1'b1, 6'd0, 1'b1, 1'b0, 1'b0});
    known_node_reports.push_back('{6'd2, 22'd131070, 1'b1, 6'd1, 1'b1, 1'b0, 1'b1});
    // source outside the nodes in use
    known_node_reports.push_back('{6'd0, 22'd0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0});
    known_node_reports.push_back('{6'd1, 22'd0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0});
    known_node_reports.push_back('{6'd2, 22'd0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b1});
    // empty store, source 1
    known_node_reports.push_back('{6'd0, 22'd0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0});
    known_node_reports.push_back('{6'd1, 22'd0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0});
    known_node_reports.push_back('{6'd2, 22'd0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b1});
    // single node with a self loop
    known_node_reports.push_back('{6'd0, 22'd0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b1});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.kind == ROW_CFG) begin
        write_node_count(s.count);
      end else begin
        repeat (s.n_known) pending_node_reports.push_back(known_node_reports.pop_front());
        send_command(s.op, s.from, s.to, s.weight, s.src, s.n_known != 0);
        take_break();
      end
    end

    // random part: each phase sets node_count, loads a graph, runs it
    phase = 0;
    while (commands_sent < COMMAND_TARGET) begin
      // one phase fills the store past capacity at the full node count
      big = (phase == 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (big) begin
        count = COUNT_BITS'(MAX_N);
      end else begin
        case ($urandom_range(0, 9))
          0:       count = '0;
          1:       count = '1;
          2:       count = COUNT_BITS'($urandom_range(MAX_N, 127));
          3:       count = COUNT_BITS'($urandom_range(13, MAX_N));
          default: count = COUNT_BITS'($urandom_range(1, 12));
        endcase
      end
      write_node_count(count);
      n = effective_nodes(count);

      // keep the store small except in the capacity phase
      if (big || store_count > 40 || $urandom_range(0, 3) != 0) begin
        send_command(FUNC_CLEAR, pick_node(n), pick_node(n), pick_weight(), pick_node(n), 0);
        take_break();
      end

      n_edges = big ? MAX_E + $urandom_range(1, 6) : $urandom_range(0, (3 * n < 24) ? 3 * n : 24);
      repeat (n_edges) begin
        // occasional noise beat with a meaningless code
        if ($urandom_range(0, 19) == 0) begin
          send_command(FUNC_UNUSED, pick_node(n), pick_node(n), pick_weight(), pick_node(n), 0);
          take_break();
        end
        send_command(FUNC_ADD, pick_node(n), pick_node(n), pick_weight(), pick_node(n), 0);
        take_break();
      end

      n_runs = big ? 2 : $urandom_range(1, 3);
      repeat (n_runs) begin
        send_command(FUNC_RUN, pick_node(n), pick_node(n), pick_weight(), pick_node(n), 0);
        take_break();
        // sometimes grow the graph between runs
        if (!big && $urandom_range(0, 4) == 0) begin
          send_command(FUNC_ADD, pick_node(n), pick_node(n), pick_weight(), pick_node(n), 0);
          take_break();
        end
      end

      // clearing must drop the overflow flag as well
      if (big) begin
        send_command(FUNC_CLEAR, pick_node(n), pick_node(n), pick_weight(), pick_node(n), 0);
        take_break();
        send_command(FUNC_RUN, pick_node(n), pick_node(n), pick_weight(), pick_node(n), 0);
      end
      phase++;
    end

    start <= 1'b0;
    while (pending_node_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (!failed && pending_node_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
